// ===== design/tcf_pkg.sv =====
// Shared types, constants and tables for the tilt complementary filter.
// No dependencies; every other design file imports this package.
package tcf_pkg;

  // CORDIC iteration count (8..24) and arctangent table length
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int STEP_W       = $clog2(TAB_LEN);

  // Datapath widths
  localparam int ANG_W  = 16;  // angles, 1/128 degree
  localparam int RATE_W = 17;  // bias-corrected rate, accelerometer operands
  localparam int XY_W   = 28;  // CORDIC x/y after scaling by 256 and gain
  localparam int Z_W    = 26;  // CORDIC angle, 1/65536 degree
  localparam int SQ_W   = 32;  // sum of squares
  localparam int ROOT_W = 16;  // square root
  localparam int BD_W   = 29;  // blend difference term
  localparam int NUM_W  = 48;  // blend numerator
  localparam int REM_W  = 49;  // divider remainder
  localparam int QUO_W  = 25;  // divider quotient

  localparam logic signed [ANG_W-1:0] ANG_LIMIT = 16'sd23040;

  // Register indexes
  localparam logic [1:0] REG_BLEND_WEIGHT   = 2'd0;
  localparam logic [1:0] REG_RATE_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_BIAS_RATE_X    = 2'd2;
  localparam logic [1:0] REG_BIAS_RATE_Y    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ1, ST_SQ2, ST_ROOT, ST_PITCH, ST_BLEND, ST_OUT
  } tcf_state_e;

  typedef enum logic [1:0] {BL_IDLE, BL_MUL, BL_DIV} tcf_bl_phase_e;

  // Status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } tcf_stat_t;

  // atan(2^-i) in 1/65536 degree, rounded
  function automatic logic [21:0] atan_tab(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // Saturate to +-180 degrees
  function automatic logic signed [ANG_W-1:0] clamp_ang(input logic signed [27:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > 28'(ANG_LIMIT)) r = ANG_LIMIT;
    else if (v < -28'(ANG_LIMIT)) r = -ANG_LIMIT;
    else r = v[ANG_W-1:0];
    return r;
  endfunction

endpackage

// ===== design/tcf_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on tcf_pkg.
module tcf_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tcf_pkg::SQ_W-1:0]     value_i,
  output logic [tcf_pkg::ROOT_W-1:0]   root_o,
  output tcf_pkg::tcf_stat_t           stat_o
);
  import tcf_pkg::*;

  logic            busy_q, done_q;
  logic [SQ_W-1:0] rem_q, res_q, bit_q;
  logic [SQ_W:0]   trial;
  logic            fits;

  // trial subtract of res + bit
  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign fits  = {1'b0, rem_q} >= trial;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      busy_q <= !bit_q[0];
      done_q <= bit_q[0];
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i;
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - trial[SQ_W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = res_q[ROOT_W-1:0];
  assign stat_o = '{busy: busy_q, done: done_q};

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("isqrt done held");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("isqrt busy at done");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("isqrt not started");

endmodule

// ===== design/tcf_cordic.sv =====
// Iterative CORDIC in vectoring mode, one micro-rotation per cycle: atan2(y, x).
// Depends on tcf_pkg.
module tcf_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [tcf_pkg::RATE_W-1:0]  y_i,
  input  logic signed [tcf_pkg::RATE_W-1:0]  x_i,
  output logic signed [tcf_pkg::ANG_W-1:0]   angle_o,
  output tcf_pkg::tcf_stat_t                 stat_o
);
  import tcf_pkg::*;

  localparam logic signed [Z_W-1:0] Z_90 = Z_W'(90 * 65536);

  logic                     busy_q, done_q, zero_q;
  logic [STEP_W-1:0]        cnt_q;
  logic signed [XY_W-1:0]   x_q, y_q, xs, ys, sx, sy;
  logic signed [Z_W-1:0]    z_q, tabv, zr, zsh;

  // operands scaled by 256
  assign xs = {{(XY_W-RATE_W-8){x_i[RATE_W-1]}}, x_i, 8'd0};
  assign ys = {{(XY_W-RATE_W-8){y_i[RATE_W-1]}}, y_i, 8'd0};

  assign sx   = x_q >>> cnt_q;
  assign sy   = y_q >>> cnt_q;
  assign tabv = $signed({{(Z_W-22){1'b0}}, atan_tab(cnt_q)});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath: quadrant pre-rotation, then micro-rotations
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      if (x_i[RATE_W-1]) begin
        if (!y_i[RATE_W-1]) begin
          x_q <= ys;
          y_q <= -xs;
          z_q <= Z_90;
        end else begin
          x_q <= -ys;
          y_q <= xs;
          z_q <= -Z_90;
        end
      end else begin
        x_q <= xs;
        y_q <= ys;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[XY_W-1]) begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + tabv;
      end else begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - tabv;
      end
    end
  end

  // 1/65536 degree to 1/128 degree, rounded, saturated
  assign zr      = z_q + Z_W'(256);
  assign zsh     = zr >>> 9;
  assign angle_o = zero_q ? '0 : clamp_ang(28'(zsh));
  assign stat_o  = '{busy: busy_q, done: done_q};

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("cordic done held");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < STEP_W'(CORDIC_STEPS)) else $error("cordic step overrun");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("cordic busy at done");

endmodule

// ===== design/tcf_blend.sv =====
// Serial blend unit: shift-add multiply by the weight, then restoring divide
// by 8192000 one quotient bit per cycle. Depends on tcf_pkg.
module tcf_blend (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [tcf_pkg::ANG_W-1:0]   angle_i,
  input  logic signed [tcf_pkg::RATE_W-1:0]  rate_i,
  input  logic [9:0]                         ms_i,
  input  logic signed [tcf_pkg::ANG_W-1:0]   acc_i,
  input  logic [15:0]                        weight_i,
  output logic signed [tcf_pkg::ANG_W-1:0]   angle_o,
  output tcf_pkg::tcf_stat_t                 stat_o
);
  import tcf_pkg::*;

  // divisor at the top quotient bit; offset = half divisor for rounding plus
  // a multiple of the divisor that makes the dividend non-negative
  localparam logic [REM_W-1:0] DIV_TOP = REM_W'(64'd8192000 << (QUO_W - 1));
  localparam logic [REM_W-1:0] BL_OFS  = DIV_TOP + REM_W'(4096000);
  localparam logic signed [QUO_W:0] Q_BIAS = (QUO_W+1)'(64'd1 << (QUO_W - 1));

  tcf_bl_phase_e             phase_q;
  logic                      done_q;
  logic [STEP_W-1:0]         cnt_q;
  logic [15:0]               w_q;
  logic signed [NUM_W-1:0]   num_q, dsh_q, num_nxt;
  logic [REM_W-1:0]          rem_q, dv_q;
  logic [QUO_W-1:0]          quo_q;
  logic signed [BD_W-1:0]    p_w, q_w;
  logic                      ge;
  logic signed [QUO_W:0]     qs;

  // a*P + (65536-a)*Q = a*(P-Q) + 65536*Q
  assign p_w = BD_W'(angle_i) * BD_W'(125)
             + BD_W'(rate_i) * BD_W'($signed({1'b0, ms_i}));
  assign q_w = BD_W'(acc_i) * BD_W'(125);

  assign num_nxt = num_q + (w_q[0] ? dsh_q : '0);
  assign ge      = rem_q >= dv_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= BL_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      phase_q <= BL_MUL;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        BL_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == STEP_W'(15)) begin
            phase_q <= BL_DIV;
            cnt_q   <= '0;
          end
        end
        BL_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == STEP_W'(QUO_W - 1)) begin
            phase_q <= BL_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      w_q   <= weight_i;
      num_q <= NUM_W'(q_w) <<< 16;
      dsh_q <= NUM_W'(p_w - q_w);
    end else if (phase_q == BL_MUL) begin
      num_q <= num_nxt;
      dsh_q <= dsh_q <<< 1;
      w_q   <= w_q >> 1;
      if (cnt_q == STEP_W'(15)) begin
        rem_q <= REM_W'(num_nxt) + BL_OFS;
        dv_q  <= DIV_TOP;
        quo_q <= '0;
      end
    end else if (phase_q == BL_DIV) begin
      if (ge) rem_q <= rem_q - dv_q;
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dv_q  <= dv_q >> 1;
    end
  end

  assign qs      = $signed({1'b0, quo_q}) - Q_BIAS;
  assign angle_o = clamp_ang(28'(qs));
  assign stat_o  = '{busy: phase_q != BL_IDLE, done: done_q};

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("blend done held");
  a_done_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(phase_q == BL_DIV)) else $error("blend done without divide");
  a_mul_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == BL_MUL && cnt_q == STEP_W'(15) && !start_i) |=> phase_q == BL_DIV)
    else $error("blend missed divide phase");

endmodule

// ===== design/tilt_complementary_filter_unit.sv =====
// Tilt complementary filter top level: roll and pitch from gyro and accelerometer.
// From input transfer to result valid: two squaring states (ST_SQ1, ST_SQ2),
// 16-step square root, 16-step pitch CORDIC (roll CORDIC overlaps), then 16-step
// serial multiply and 25-step divide in the blend units.
// One item at a time: a new sample is taken only once the previous result has left ST_OUT.
// Reset (async, active low) clears the filter angles to 0 and restores register defaults.
module tilt_complementary_filter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [15:0]                 rate_x_i,
  input  logic signed [15:0]                 rate_y_i,
  input  logic signed [15:0]                 accel_x_i,
  input  logic signed [15:0]                 accel_y_i,
  input  logic signed [15:0]                 accel_z_i,
  input  logic [9:0]                         elapsed_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [15:0]                 roll_angle_o,
  output logic signed [15:0]                 pitch_angle_o
);
  import tcf_pkg::*;

  tcf_state_e state_q, state_d;

  logic [15:0]              weight_q;
  logic [14:0]              thr_q;
  logic signed [15:0]       bias_x_q, bias_y_q;
  logic signed [ANG_W-1:0]  roll_acc_q, pitch_acc_q, roll_acc_d, pitch_acc_d;
  logic signed [ANG_W-1:0]  out_roll_q, out_pitch_q;
  logic                     out_valid_q;
  logic signed [RATE_W-1:0] rx_q, ry_q, nax_q, ay_q, az_q;
  logic [9:0]               ms_q;
  logic [SQ_W-1:0]          sq_q, sq_sum;
  logic signed [RATE_W-1:0] mul_a;
  logic signed [33:0]       sqp;
  logic [RATE_W-1:0]        arx, ary;
  logic                     upd_x, upd_y, in_xfer, out_free;

  logic                     sq_start, roll_start, pitch_start, blend_start;
  logic [ROOT_W-1:0]        root;
  logic signed [ANG_W-1:0]  roll_ang, pitch_ang, roll_new, pitch_new;
  tcf_stat_t                sq_stat, roll_stat, pitch_stat, bl_r_stat, bl_p_stat;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= 16'd64225;
      thr_q    <= '0;
      bias_x_q <= '0;
      bias_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BLEND_WEIGHT:   weight_q <= cfg_data_i;
        REG_RATE_THRESHOLD: thr_q    <= cfg_data_i[14:0];
        REG_BIAS_RATE_X:    bias_x_q <= cfg_data_i;
        REG_BIAS_RATE_Y:    bias_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input capture with bias removal
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rx_q  <= RATE_W'(rate_x_i) - RATE_W'(bias_x_q);
      ry_q  <= RATE_W'(rate_y_i) - RATE_W'(bias_y_q);
      nax_q <= -RATE_W'(accel_x_i);
      ay_q  <= RATE_W'(accel_y_i);
      az_q  <= RATE_W'(accel_z_i);
      ms_q  <= elapsed_ms_i;
    end
  end

  // ay^2 + az^2 on one multiplier: ay^2 in ST_SQ1, az^2 added in ST_SQ2
  assign mul_a  = (state_q == ST_SQ1) ? ay_q : az_q;
  assign sqp    = 34'(mul_a) * 34'(mul_a);
  assign sq_sum = sq_q + sqp[SQ_W-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SQ1) sq_q <= sqp[SQ_W-1:0];
  end

  tcf_isqrt u_isqrt (
    .clk_i, .rst_ni,
    .start_i (sq_start),
    .value_i (sq_sum),
    .root_o  (root),
    .stat_o  (sq_stat)
  );

  tcf_cordic u_cordic_roll (
    .clk_i, .rst_ni,
    .start_i (roll_start),
    .y_i     (ay_q),
    .x_i     (az_q),
    .angle_o (roll_ang),
    .stat_o  (roll_stat)
  );

  tcf_cordic u_cordic_pitch (
    .clk_i, .rst_ni,
    .start_i (pitch_start),
    .y_i     (nax_q),
    .x_i     ($signed({1'b0, root})),
    .angle_o (pitch_ang),
    .stat_o  (pitch_stat)
  );

  tcf_blend u_blend_roll (
    .clk_i, .rst_ni,
    .start_i  (blend_start),
    .angle_i  (roll_acc_q),
    .rate_i   (ry_q),
    .ms_i     (ms_q),
    .acc_i    (roll_ang),
    .weight_i (weight_q),
    .angle_o  (roll_new),
    .stat_o   (bl_r_stat)
  );

  tcf_blend u_blend_pitch (
    .clk_i, .rst_ni,
    .start_i  (blend_start),
    .angle_i  (pitch_acc_q),
    .rate_i   (rx_q),
    .ms_i     (ms_q),
    .acc_i    (pitch_ang),
    .weight_i (weight_q),
    .angle_o  (pitch_new),
    .stat_o   (bl_p_stat)
  );

  // strict magnitude test against the threshold
  assign arx   = rx_q[RATE_W-1] ? RATE_W'(-rx_q) : RATE_W'(rx_q);
  assign ary   = ry_q[RATE_W-1] ? RATE_W'(-ry_q) : RATE_W'(ry_q);
  assign upd_x = arx > {2'b00, thr_q};
  assign upd_y = ary > {2'b00, thr_q};

  assign roll_acc_d  = upd_y ? roll_new : roll_acc_q;
  assign pitch_acc_d = upd_x ? pitch_new : pitch_acc_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer) state_d = ST_SQ1;
      ST_SQ1:   state_d = ST_SQ2;
      ST_SQ2:   state_d = ST_ROOT;
      ST_ROOT:  if (sq_stat.done) state_d = ST_PITCH;
      ST_PITCH: if (pitch_stat.done) state_d = ST_BLEND;
      ST_BLEND: if (bl_p_stat.done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // unit starts and handshake
  always_comb begin
    in_stall_o  = state_q != ST_IDLE;
    roll_start  = state_q == ST_SQ1;
    sq_start    = state_q == ST_SQ2;
    pitch_start = (state_q == ST_ROOT) && sq_stat.done;
    blend_start = (state_q == ST_PITCH) && pitch_stat.done;
  end

  // state, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      roll_acc_q  <= '0;
      pitch_acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        roll_acc_q  <= roll_acc_d;
        pitch_acc_q <= pitch_acc_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_roll_q  <= roll_acc_d;
      out_pitch_q <= pitch_acc_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = out_roll_q;
  assign pitch_angle_o = out_pitch_q;

  a_roll_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PITCH && pitch_stat.done) |-> !roll_stat.busy)
    else $error("roll angle not ready for blend");
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT)) else $error("spurious result");
  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    roll_acc_q <= ANG_LIMIT && roll_acc_q >= -ANG_LIMIT) else $error("roll out of range");
  a_blend_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_p_stat.done |-> (bl_r_stat.done && state_q == ST_BLEND))
    else $error("blend units out of step");

endmodule

// ===== test/tb_tilt_complementary_filter_unit.sv =====
// Testbench for tilt_complementary_filter_unit: directed and random samples, checked
// against a cycle-free predictor of the roll/pitch filter. Depends on tcf_pkg and the top level.
`timescale 1ns / 1ps

module tb_tilt_complementary_filter_unit;
  import tcf_pkg::*;

  typedef struct {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [9:0]         elapsed_ms;
  } imu_sample_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } tilt_t;

  localparam longint ANG_MAX = 23040;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] rate_x_i = '0, rate_y_i = '0;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic [9:0] elapsed_ms_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] roll_angle_o, pitch_angle_o;

  tilt_complementary_filter_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Filter state and register copies
  logic [15:0]        mdl_weight;
  logic [14:0]        mdl_thresh;
  logic signed [15:0] mdl_bias_x, mdl_bias_y;
  logic signed [15:0] mdl_roll, mdl_pitch;

  tilt_t expected_tilt[$];
  int    n_errors = 0;
  int    n_checked = 0;
  int    n_sent = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  bit    hold_req = 1'b0;
  int    hold_cnt = 0;

  localparam longint ATAN_DEG16[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint sat_angle(longint v);
    if (v > ANG_MAX) return ANG_MAX;
    if (v < -ANG_MAX) return -ANG_MAX;
    return v;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Vectoring CORDIC atan2, result in 1/128 degree
  function automatic longint vec_atan2(longint y, longint x);
    longint z, t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x *= 256;
    y *= 256;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ATAN_DEG16[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ATAN_DEG16[i];
      end
      x = nx;
      y = ny;
    end
    return sat_angle((z + 256) >>> 9);
  endfunction

  function automatic longint blend_angle(longint ang, longint r, longint ms, longint acc);
    longint a, num;
    a = longint'(mdl_weight);
    num = a * (125 * ang + r * ms) + (65536 - a) * 125 * acc;
    return sat_angle(floor_div(num + 4096000, 8192000));
  endfunction

  // Advance the filter by one sample and queue the expected angles
  task automatic predict_tilt(input imu_sample_t s);
    longint rx, ry, ay, az, mag, acc_p, acc_r;
    tilt_t e;
    rx = longint'(s.rate_x) - longint'(mdl_bias_x);
    ry = longint'(s.rate_y) - longint'(mdl_bias_y);
    ay = s.accel_y;
    az = s.accel_z;
    mag = int_sqrt(longint'(ay * ay + az * az));
    acc_p = vec_atan2(-longint'(s.accel_x), mag);
    acc_r = vec_atan2(ay, az);
    if ((rx < 0 ? -rx : rx) > longint'(mdl_thresh))
      mdl_pitch = 16'(blend_angle(mdl_pitch, rx, s.elapsed_ms, acc_p));
    if ((ry < 0 ? -ry : ry) > longint'(mdl_thresh))
      mdl_roll = 16'(blend_angle(mdl_roll, ry, s.elapsed_ms, acc_r));
    e.roll = mdl_roll;
    e.pitch = mdl_pitch;
    expected_tilt.push_back(e);
  endtask

  // One sample transfer, with random idle cycles ahead of it
  task automatic send_sample(input imu_sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    rate_x_i     <= s.rate_x;
    rate_y_i     <= s.rate_y;
    accel_x_i    <= s.accel_x;
    accel_y_i    <= s.accel_y;
    accel_z_i    <= s.accel_z;
    elapsed_ms_i <= s.elapsed_ms;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_tilt(s);
    n_sent++;
  endtask

  task automatic send_fields(input int rx, ry, ax, ay, az, ms);
    imu_sample_t s;
    s.rate_x = 16'(rx); s.rate_y = 16'(ry);
    s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
    s.elapsed_ms = 10'(ms);
    send_sample(s);
  endtask

  // Wait for all results, then let the block settle
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_tilt.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // One register write; the write enable is dropped again before the task returns
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_BLEND_WEIGHT:   mdl_weight = data;
      REG_RATE_THRESHOLD: mdl_thresh = data[14:0];
      REG_BIAS_RATE_X:    mdl_bias_x = data;
      REG_BIAS_RATE_Y:    mdl_bias_y = data;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [15:0] w, th, bx, by);
    cfg_write(REG_BLEND_WEIGHT, w);
    cfg_write(REG_RATE_THRESHOLD, th);
    cfg_write(REG_BIAS_RATE_X, bx);
    cfg_write(REG_BIAS_RATE_Y, by);
  endtask

  function automatic int rand_word;
    case ($urandom_range(9))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(64) - 32;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // Mostly tilt-like accelerometer data and modest rates, sometimes raw noise
  function automatic imu_sample_t rand_sample;
    imu_sample_t s;
    if ($urandom_range(3) == 0) begin
      s.rate_x = 16'(rand_word()); s.rate_y = 16'(rand_word());
      s.accel_x = 16'(rand_word()); s.accel_y = 16'(rand_word());
      s.accel_z = 16'(rand_word());
      s.elapsed_ms = 10'($urandom_range(1023));
    end else begin
      s.rate_x = 16'(int'($urandom_range(4000)) - 2000);
      s.rate_y = 16'(int'($urandom_range(4000)) - 2000);
      s.accel_x = 16'(int'($urandom_range(600)) - 300);
      s.accel_y = 16'(int'($urandom_range(600)) - 300);
      s.accel_z = 16'(int'($urandom_range(600)) - 300);
      s.elapsed_ms = 10'($urandom_range(1, 50));
    end
    return s;
  endfunction

  // Long receiver hold, counted down in cycles
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_cnt <= 400;
      hold_req <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver: random or held stall, result check
  always @(posedge clk_i) begin
    tilt_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tilt.size() == 0) begin
        $error("result transfer with no sample pending");
        n_errors++;
      end else begin
        e = expected_tilt.pop_front();
        n_checked++;
        if (roll_angle_o !== e.roll) begin
          $error("roll_angle: expected %0d, actual %0d", e.roll, roll_angle_o);
          n_errors++;
        end
        if (pitch_angle_o !== e.pitch) begin
          $error("pitch_angle: expected %0d, actual %0d", e.pitch, pitch_angle_o);
          n_errors++;
        end
      end
    end
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Extremes and the named corner cases
  task automatic test_directed;
    send_fields(0, 0, 0, 0, 0, 0);                      // both atan2 operands zero
    send_fields(32767, -32768, 32767, 0, -100, 1023);   // roll atan2 at +180
    send_fields(-32768, 32767, -32768, 32767, 32767, 1000);
    send_fields(32767, 32767, 0, -32768, -32768, 1023); // drives saturation
    send_fields(-32768, -32768, 100, 0, 0, 1023);
    send_fields(100, -200, -32768, 0, 0, 10);
    send_fields(20, -20, 300, -300, 300, 512);
    drain();
    cfg_all(16'd32768, 16'hFFFF, 16'sd0, 16'sd0);       // threshold bit 15 ignored
    cfg_write(REG_RATE_THRESHOLD, 16'd100);
    send_fields(100, -100, 50, 50, 50, 20);             // exactly at threshold: hold
    send_fields(-100, 100, 50, 50, 50, 20);
    send_fields(101, -101, 50, 50, 50, 20);
    send_fields(-101, 101, -50, -50, -50, 20);
    drain();
    cfg_all(16'd0, 16'd0, 16'h8000, 16'h7FFF);
    send_fields(-32768, 32767, 1, 1, 1, 1);             // rates cancel the bias
    send_fields(32767, -32768, -1, -1, 1, 1023);
    send_fields(0, 0, 200, 0, -200, 5);
    drain();
    cfg_all(16'hFFFF, 16'd0, 16'h0000, 16'h0000);
    send_fields(32767, 32767, 0, 0, 1, 1023);
    send_fields(-32768, -32768, 0, 1, 0, 1023);
    send_fields(5, 5, 0, 0, 0, 0);
    drain();
  endtask

  task automatic run_random(input int n, input int ip, input int sp);
    idle_pct = ip;
    stall_pct = sp;
    repeat (n) send_sample(rand_sample());
    drain();
  endtask

  // Random samples across idle mixes and register settings
  task automatic test_random;
    cfg_all(16'd64225, 16'd0, 16'd0, 16'd0);
    run_random(150, 0, 0);
    cfg_all(16'($urandom_range(65535)), 16'($urandom_range(200)),
            16'(int'($urandom_range(400)) - 200), 16'(int'($urandom_range(400)) - 200));
    run_random(150, 77, 0);
    cfg_all(16'd65535, 16'd32767, 16'h8000, 16'h7FFF);
    run_random(100, 0, 77);
    cfg_all(16'd0, 16'($urandom_range(32767)), 16'($urandom_range(65535)),
            16'($urandom_range(65535)));
    run_random(100, 15, 15);
    cfg_all(16'd60000, 16'd30, 16'd12, 16'hFFF0);
    run_random(100, 15, 15);
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // Long receiver hold fills the block; then a pause until all results return
  task automatic test_backpressure;
    cfg_all(16'd64225, 16'd5, 16'd0, 16'd0);
    hold_req = 1'b1;
    repeat (12) send_sample(rand_sample());
    in_valid_i <= 1'b0;
    while (expected_tilt.size() != 0) @(posedge clk_i);
    repeat (20) send_sample(rand_sample());
    drain();
  endtask

  initial begin
    mdl_weight = 16'd64225;
    mdl_thresh = '0;
    mdl_bias_x = '0;
    mdl_bias_y = '0;
    mdl_roll = '0;
    mdl_pitch = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    $display("Covered %0d samples, %0d results checked, over several register settings",
             n_sent, n_checked);
    $display("and idle/stall mixes including a long output hold.");
    if (n_errors == 0 && expected_tilt.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
